>>> rtl/rmbf_pkg.sv
package rmbf_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_RIGHT  = 5'b00100,
        ST_LEFT   = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic pair;
    } t_cell_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

endpackage

>>> rtl/rmbf_cell.sv
module rmbf_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rmbf_pkg::t_cell_ctrl i_ctrl,
    input  rmbf_pkg::t_sample   i_sample,
    input  rmbf_pkg::t_sample   i_left_val,
    input  rmbf_pkg::t_sample   i_right_val,
    input  logic                i_left_swap,
    output rmbf_pkg::t_sample   o_val,
    output logic                o_gt,
    output logic                o_swap
);
    import rmbf_pkg::*;

    t_sample r_val;
    t_sample n_val;

    assign o_val  = r_val;
    assign o_gt   = r_val > i_right_val;
    assign o_swap = i_ctrl.pair & o_gt;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.load) begin
            n_val = i_sample;
        end else if (o_swap) begin
            n_val = i_right_val;
        end else if (i_left_swap) begin
            n_val = i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

endmodule

>>> rtl/rmbf_seq.sv
module rmbf_seq #(
    parameter int WINDOW = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [WINDOW-2:0]                   i_gt,
    input  logic                                i_out_busy,
    output rmbf_pkg::t_cell_ctrl [WINDOW-1:0]   o_ctrl,
    output rmbf_pkg::t_seq_stat                 o_stat
);
    import rmbf_pkg::*;

    t_state            r_state, n_state;
    logic [WINDOW-1:0] r_slot, n_slot;
    logic [WINDOW-2:0] r_pair, n_pair;
    logic              go_right;
    logic              go_left;

    assign go_right = |(r_slot[WINDOW-2:0] & i_gt);
    assign go_left  = |(r_slot[WINDOW-1:1] & i_gt);

    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            o_ctrl[k].load = i_accept & r_slot[k];
            o_ctrl[k].pair = 1'b0;
        end
        for (int k = 0; k < WINDOW - 1; k++) begin
            o_ctrl[k].pair = r_pair[k];
        end
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE) && !i_out_busy;

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_pair  = r_pair;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (go_right) begin
                    n_pair  = r_slot[WINDOW-2:0];
                    n_state = ST_RIGHT;
                end else if (go_left) begin
                    n_pair  = r_slot[WINDOW-1:1];
                    n_state = ST_LEFT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RIGHT: begin
                if (r_pair[WINDOW-2]) begin
                    n_pair  = '0;
                    n_state = ST_DONE;
                end else begin
                    n_pair = r_pair << 1;
                end
            end
            ST_LEFT: begin
                if (r_pair[0]) begin
                    n_pair  = '0;
                    n_state = ST_DONE;
                end else begin
                    n_pair = r_pair >> 1;
                end
            end
            ST_DONE: begin
                if (!i_out_busy) begin
                    n_slot  = {r_slot[WINDOW-2:0], r_slot[WINDOW-1]};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_pair  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= {{(WINDOW-1){1'b0}}, 1'b1};
            r_pair  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_pair  <= n_pair;
        end
    end

endmodule

>>> rtl/running_median_bubble_filter.sv
// Flow: an accepted transaction passes through decide, a bubble pass if needed
// (one compare-swap per cycle), done and the output register to o_valid.
// One transaction at a time: o_stall holds the next off until the single compare-swap
// token has walked the cell chain and the result is registered, longer on a stall.
// Reset: synchronous on i_rst_n; all window cells cleared to zero, slot at
// entry 0, output register empty.
module running_median_bubble_filter #(
    parameter int WINDOW = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  rmbf_pkg::t_sample       i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output rmbf_pkg::t_sample       o_median
);
    import rmbf_pkg::*;

    localparam int MID = WINDOW / 2;

    t_cell_ctrl [WINDOW-1:0] cell_ctrl;
    t_seq_stat               seq_stat;
    t_sample                 cell_val [WINDOW];
    logic [WINDOW-1:0]       cell_gt;
    logic [WINDOW-1:0]       cell_swap;
    logic                    accept;
    logic                    r_valid, n_valid;
    t_sample                 r_median, n_median;

    assign accept   = i_valid && !seq_stat.busy;
    assign o_stall  = seq_stat.busy;
    assign o_valid  = r_valid;
    assign o_median = r_median;

    rmbf_seq #(
        .WINDOW(WINDOW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_gt       (cell_gt[WINDOW-2:0]),
        .i_out_busy (r_valid && i_stall),
        .o_ctrl     (cell_ctrl),
        .o_stat     (seq_stat)
    );

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        rmbf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (cell_ctrl[k]),
            .i_sample    (i_sample),
            .i_left_val  ((k > 0) ? cell_val[(k > 0) ? k - 1 : 0] : cell_val[k]),
            .i_right_val ((k < WINDOW - 1) ? cell_val[(k < WINDOW - 1) ? k + 1 : k]
                                           : cell_val[k]),
            .i_left_swap ((k > 0) ? cell_swap[(k > 0) ? k - 1 : 0] : 1'b0),
            .o_val       (cell_val[k]),
            .o_gt        (cell_gt[k]),
            .o_swap      (cell_swap[k])
        );
    end

    always_comb begin
        n_valid  = r_valid;
        n_median = r_median;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (seq_stat.done) begin
            n_valid  = 1'b1;
            n_median = cell_val[MID];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_median <= n_median;
    end

endmodule

>>> rtl/rmbf_checker.sv
module rmbf_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input rmbf_pkg::t_sample i_sample,
    input logic              o_valid,
    input logic              i_stall,
    input rmbf_pkg::t_sample o_median
);
    import rmbf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_median)))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepted transaction");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && $past(i_rst_n)) |-> $past(o_stall))
        else $error("result appeared without work in progress");

    a_idle_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_stall) && $past(i_rst_n)) |-> o_valid)
        else $error("went idle without presenting a result");

    a_sample_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> !$isunknown(i_sample))
        else $error("accepted sample has unknown bits");

endmodule

bind running_median_bubble_filter rmbf_checker u_rmbf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_sample (i_sample),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_median (o_median)
);

>>> test/running_median_bubble_filter_test.sv
`timescale 1ns / 1ps

module running_median_bubble_filter_test;
    import rmbf_pkg::*;

    localparam int WINDOW      = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic    i_clk    = 1'b0;
    logic    i_rst_n  = 1'b0;
    logic    i_valid  = 1'b0;
    logic    i_stall  = 1'b0;
    t_sample i_sample = '0;
    logic    o_stall;
    logic    o_valid;
    t_sample o_median;

    t_sample win_entries [WINDOW];
    int      win_slot;
    t_sample median_queue [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      stall_left     = 0;
    logic    src_idle_on    = 1'b0;
    logic    sink_idle_on   = 1'b0;
    logic    sink_hold      = 1'b0;

    t_sample corner_values [0:19] = '{
        16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001,
        16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh5555,
        16'shaaaa, 16'sh7ffe, 16'sh8001, 16'sh0000, 16'sh0000,
        16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000
    };

    running_median_bubble_filter #(
        .WINDOW (WINDOW)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_median (o_median)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("running_median_bubble_filter test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_stall <= sink_hold;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (median_queue.size() == 0) begin
                $display("%0t: unexpected median, expected none, actual %0d",
                         $time, o_median);
                mismatch_count++;
            end else begin
                if (o_median !== median_queue[0]) begin
                    $display("%0t: median mismatch, expected %0d, actual %0d",
                             $time, median_queue[0], o_median);
                    mismatch_count++;
                end
                void'(median_queue.pop_front());
            end
        end
    end

    // insert into the slot, run at most one bubble pass, advance the slot
    task automatic predict_median(input t_sample value);
        int      s;
        int      k;
        t_sample t;
        s = win_slot;
        win_entries[s] = value;
        if (s + 1 < WINDOW && win_entries[s] > win_entries[s + 1]) begin
            for (k = s; k + 1 < WINDOW; k++) begin
                if (win_entries[k] > win_entries[k + 1]) begin
                    t = win_entries[k];
                    win_entries[k] = win_entries[k + 1];
                    win_entries[k + 1] = t;
                end
            end
        end else if (s > 0 && win_entries[s - 1] > win_entries[s]) begin
            for (k = s; k > 0; k--) begin
                if (win_entries[k] < win_entries[k - 1]) begin
                    t = win_entries[k];
                    win_entries[k] = win_entries[k - 1];
                    win_entries[k - 1] = t;
                end
            end
        end
        win_slot = (s + 1) % WINDOW;
        median_queue.push_back(win_entries[WINDOW / 2]);
    endtask

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_sample(input t_sample value);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (o_stall);
        predict_median(value);
    endtask

    task automatic test_field_extremes();
        int k;
        for (k = 0; k < 20; k++) send_sample(corner_values[k]);
    endtask

    task automatic test_random_full_range(input int count);
        int k;
        for (k = 0; k < count; k++) send_sample(t_sample'($urandom_range(0, 65535)));
    endtask

    // narrow values give many equal neighbours
    task automatic test_random_narrow(input int count);
        int k;
        int v;
        for (k = 0; k < count; k++) begin
            v = $urandom_range(0, 8);
            send_sample(t_sample'(v - 4));
        end
    endtask

    // rising and falling runs force long bubble passes both ways
    task automatic test_ramps(input int count);
        int k;
        int v;
        int step;
        int run;
        k = 0;
        while (k < count) begin
            v    = $urandom_range(0, 65535) - 32768;
            step = $urandom_range(1, 4000);
            if ($urandom_range(0, 1) == 1) step = -step;
            for (run = $urandom_range(7, 14); run > 0 && k < count; run--) begin
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                send_sample(t_sample'(v));
                v += step;
                k++;
            end
        end
    endtask

    // receiver holds off while the sender keeps offering transactions
    task automatic test_backpressure(input int count);
        int k;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        for (k = 0; k < count; k++) send_sample(t_sample'($urandom_range(0, 65535)));
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_steady_stream(input int count);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_full_range(count / 2);
        test_ramps(count - count / 2);
    endtask

    initial begin
        foreach (win_entries[k]) win_entries[k] = '0;
        win_slot = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_random_full_range(600);
        test_random_narrow(400);
        test_ramps(300);
        test_backpressure(40);
        test_steady_stream(350);

        i_valid <= 1'b0;
        while (median_queue.size() != 0) @(posedge i_clk);
        repeat (WINDOW + 6) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("running_median_bubble_filter test passed");
        end else begin
            $display("running_median_bubble_filter test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rmbf_pkg.sv
rtl/rmbf_cell.sv
rtl/rmbf_seq.sv
rtl/running_median_bubble_filter.sv
rtl/rmbf_checker.sv
test/running_median_bubble_filter_test.sv
